### src/salru_pkg.sv
// Shared types and constants for the set-associative LRU cache model.
// Used by the way compare unit and the top level; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package salru_pkg;

    localparam int ADDR_W  = 64;
    // The offset and the set index take at least one bit each.
    localparam int TAG_W   = ADDR_W - 2;
    localparam int STAMP_W = 32;
    localparam int COUNT_W = 32;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 6;
    localparam int OUT_TDATA_W = 104;

    localparam logic [CFG_ADDR_W-1:0] REG_SET_BITS   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WAYS_USED  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_BLOCK_BITS = 2'd2;

    localparam logic [3:0] SET_BITS_RESET   = 4'd4;
    localparam logic [3:0] WAYS_USED_RESET  = 4'd1;
    localparam logic [5:0] BLOCK_BITS_RESET = 6'd4;

    typedef enum logic [1:0] {
        OUTCOME_HIT   = 2'd0,
        OUTCOME_FILL  = 2'd1,
        OUTCOME_EVICT = 2'd2
    } outcome_t;

    // Sequencer commands to the way compare unit.
    typedef struct packed {
        logic start;
        logic step;
    } scan_ctl_t;

    // Status of the way compare unit back to the sequencer.
    typedef struct packed {
        logic match_now;
        logic hit;
        logic empty_seen;
    } scan_stat_t;

endpackage

`default_nettype wire

### src/salru_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Used for the line store and the per-set valid store; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module salru_ram #(
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 4
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [2**ADDR_W];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

### src/salru_way_unit.sv
// Shared way compare unit: examines one line per step and keeps the running
// empty-way, least-recently-used and hit results. Depends on salru_pkg.
`timescale 1ns / 1ps
`default_nettype none

module salru_way_unit #(
    parameter int WAY_IDX_W = 3
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire salru_pkg::scan_ctl_t          ctl,
    input  wire logic [WAY_IDX_W-1:0]          way,
    input  wire logic                          line_valid,
    input  wire logic [salru_pkg::TAG_W-1:0]   line_tag,
    input  wire logic [salru_pkg::STAMP_W-1:0] line_stamp,
    input  wire logic [salru_pkg::TAG_W-1:0]   key_tag,
    output salru_pkg::scan_stat_t              stat,
    output logic      [WAY_IDX_W-1:0]          empty_way,
    output logic      [WAY_IDX_W-1:0]          lru_way
);

    logic                          hit_reg, hit_next;
    logic                          empty_seen_reg, empty_seen_next;
    logic                          lru_seen_reg, lru_seen_next;
    logic [WAY_IDX_W-1:0]          empty_way_reg, empty_way_next;
    logic [WAY_IDX_W-1:0]          lru_way_reg, lru_way_next;
    logic [salru_pkg::STAMP_W-1:0] min_stamp_reg, min_stamp_next;
    logic                          match_now;

    assign match_now = ctl.step && line_valid && (line_tag == key_tag);

    always_comb
    begin
        hit_next        = hit_reg;
        empty_seen_next = empty_seen_reg;
        lru_seen_next   = lru_seen_reg;
        empty_way_next  = empty_way_reg;
        lru_way_next    = lru_way_reg;
        min_stamp_next  = min_stamp_reg;
        if (ctl.start)
        begin
            hit_next        = 1'b0;
            empty_seen_next = 1'b0;
            lru_seen_next   = 1'b0;
        end
        else if (ctl.step)
        begin
            if (!line_valid)
            begin
                if (!empty_seen_reg)
                begin
                    empty_seen_next = 1'b1;
                    empty_way_next  = way;
                end
            end
            else
            begin
                // Strict compare keeps the lowest way on equal stamps.
                if (!lru_seen_reg || (line_stamp < min_stamp_reg))
                begin
                    lru_seen_next  = 1'b1;
                    lru_way_next   = way;
                    min_stamp_next = line_stamp;
                end
                if (match_now)
                begin
                    hit_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg        <= 1'b0;
            empty_seen_reg <= 1'b0;
            lru_seen_reg   <= 1'b0;
        end
        else
        begin
            hit_reg        <= hit_next;
            empty_seen_reg <= empty_seen_next;
            lru_seen_reg   <= lru_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        empty_way_reg <= empty_way_next;
        lru_way_reg   <= lru_way_next;
        min_stamp_reg <= min_stamp_next;
    end

    assign stat.match_now  = match_now;
    assign stat.hit        = hit_reg;
    assign stat.empty_seen = empty_seen_reg;
    assign empty_way       = empty_way_reg;
    assign lru_way         = lru_way_reg;

endmodule

`default_nettype wire

### src/set_assoc_lru_cache_sim.sv
// Set-associative cache simulator with true LRU replacement.
//
// Input channel s_*: one item per access, tdata holds the 64-bit address.
// Output channel m_*: one item per access with the outcome (hit, fill of an
// empty line, or eviction) and the saturating hit, miss and eviction counts.
// Configuration: cfg_we writes cfg_wdata into register cfg_addr (0 set index
// bits, 1 ways in use, 2 block offset bits); write only while idle.
//
// Each item passes from acceptance to result through the address split, the
// set read, a scan of W ways, where W is the number of ways examined (the
// ways in use, or fewer on an early hit), in which one shared compare unit
// examines one way per cycle, and the write-back.
// The block takes one item at a time; s_tready is high only while idle, so
// a new item is not taken until the last one has been written back.
// The result sits in an output register; a new item may be split and
// scanned while it waits, and write-back waits until that result is taken.
// After reset the valid store is cleared one set per cycle, over all
// 2**MAX_SET_BITS sets; s_tready stays low meanwhile.
// Depends on salru_pkg, salru_ram and salru_way_unit.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_lru_cache_sim #(
    parameter int MAX_SET_BITS = 8,
    parameter int MAX_WAYS     = 8
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // s_tdata: address[63:0]
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [salru_pkg::ADDR_W-1:0]        s_tdata,
    // m_tdata: outcome[1:0], hit_count[33:2], miss_count[65:34],
    // eviction_count[97:66], zero fill [103:98]
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic      [salru_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  wire logic                                cfg_we,
    input  wire logic [salru_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [salru_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int SET_W     = MAX_SET_BITS;
    localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_CNT_W = WAY_IDX_W + 1;
    localparam int LINE_W    = salru_pkg::TAG_W + salru_pkg::STAMP_W;
    localparam int TAG_W     = salru_pkg::TAG_W;
    localparam int STAMP_W   = salru_pkg::STAMP_W;
    localparam int COUNT_W   = salru_pkg::COUNT_W;
    localparam int ADDR_W    = salru_pkg::ADDR_W;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_SHIFT  = 7'b0000100,
        ST_SPLIT  = 7'b0001000,
        ST_LOAD   = 7'b0010000,
        ST_SCAN   = 7'b0100000,
        ST_UPDATE = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0] set_bits_reg;
    logic [3:0] ways_used_reg;
    logic [5:0] block_bits_reg;

    logic [3:0]           set_bits_eff;
    logic [WAY_CNT_W-1:0] ways_eff;
    logic [5:0]           block_bits_eff;

    logic [ADDR_W-1:0]    addr_reg;
    logic [ADDR_W-1:0]    shift_reg;
    logic [SET_W-1:0]     set_reg;
    logic [TAG_W-1:0]     tag_reg;
    logic [WAY_IDX_W-1:0] way_reg, way_next;
    logic [SET_W-1:0]     clr_reg;

    logic [STAMP_W-1:0] tick_reg;
    logic [COUNT_W-1:0] hits_reg, misses_reg, evictions_reg;

    logic                            out_valid_reg;
    logic [salru_pkg::OUT_TDATA_W-1:0] out_data_reg;

    logic [LINE_W-1:0]    line_rd_data;
    logic [MAX_WAYS-1:0]  valid_rd_data;
    logic                 line_wr_en;
    logic                 valid_wr_en;
    logic [SET_W-1:0]     valid_wr_addr;
    logic [MAX_WAYS-1:0]  valid_wr_data;

    salru_pkg::scan_ctl_t  scan_ctl;
    salru_pkg::scan_stat_t scan_stat;
    logic [WAY_IDX_W-1:0]  empty_way;
    logic [WAY_IDX_W-1:0]  lru_way;

    logic                 last_way;
    logic                 update_go;
    logic [WAY_IDX_W-1:0] victim;
    salru_pkg::outcome_t  outcome;
    logic [STAMP_W-1:0]   tick_inc;
    logic [MAX_WAYS-1:0]  victim_mask;

    // Configuration registers, with out-of-range values folded into range.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_bits_reg   <= salru_pkg::SET_BITS_RESET;
            ways_used_reg  <= salru_pkg::WAYS_USED_RESET;
            block_bits_reg <= salru_pkg::BLOCK_BITS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                salru_pkg::REG_SET_BITS:   set_bits_reg   <= cfg_wdata[3:0];
                salru_pkg::REG_WAYS_USED:  ways_used_reg  <= cfg_wdata[3:0];
                salru_pkg::REG_BLOCK_BITS: block_bits_reg <= cfg_wdata;
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        if (set_bits_reg == 4'd0)
            set_bits_eff = 4'd1;
        else if (int'(set_bits_reg) > MAX_SET_BITS)
            set_bits_eff = 4'(MAX_SET_BITS);
        else
            set_bits_eff = set_bits_reg;

        if (ways_used_reg == 4'd0)
            ways_eff = WAY_CNT_W'(1);
        else if (int'(ways_used_reg) > MAX_WAYS)
            ways_eff = WAY_CNT_W'(MAX_WAYS);
        else
            ways_eff = WAY_CNT_W'(ways_used_reg);

        block_bits_eff = (block_bits_reg == 6'd0) ? 6'd1 : block_bits_reg;
    end

    assign last_way  = ({1'b0, way_reg} + WAY_CNT_W'(1)) == ways_eff;
    assign update_go = !out_valid_reg || m_tready;
    assign tick_inc  = tick_reg + STAMP_W'(1);

    always_comb
    begin
        if (scan_stat.hit)
        begin
            victim  = way_reg;
            outcome = salru_pkg::OUTCOME_HIT;
        end
        else if (scan_stat.empty_seen)
        begin
            victim  = empty_way;
            outcome = salru_pkg::OUTCOME_FILL;
        end
        else
        begin
            victim  = lru_way;
            outcome = salru_pkg::OUTCOME_EVICT;
        end
        victim_mask = MAX_WAYS'(1) << victim;
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        way_next       = way_reg;
        scan_ctl.start = 1'b0;
        scan_ctl.step  = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_reg == {SET_W{1'b1}})
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                scan_ctl.start = 1'b1;
                way_next       = '0;
                state_next     = ST_SCAN;
            end
            ST_SCAN:
            begin
                scan_ctl.step = 1'b1;
                if (scan_stat.match_now || last_way)
                    state_next = ST_UPDATE;
                else
                    way_next = way_reg + WAY_IDX_W'(1);
            end
            ST_UPDATE:
            begin
                if (update_go)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            way_reg       <= '0;
            tick_reg      <= '0;
            hits_reg      <= '0;
            misses_reg    <= '0;
            evictions_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            way_reg   <= way_next;
            if (state_reg == ST_CLEAR)
                clr_reg <= clr_reg + SET_W'(1);
            if ((state_reg == ST_UPDATE) && update_go)
            begin
                out_valid_reg <= 1'b1;
                tick_reg      <= tick_inc;
                if (scan_stat.hit)
                begin
                    if (hits_reg != {COUNT_W{1'b1}})
                        hits_reg <= hits_reg + COUNT_W'(1);
                end
                else
                begin
                    if (misses_reg != {COUNT_W{1'b1}})
                        misses_reg <= misses_reg + COUNT_W'(1);
                    if (!scan_stat.empty_seen && (evictions_reg != {COUNT_W{1'b1}}))
                        evictions_reg <= evictions_reg + COUNT_W'(1);
                end
            end
            else if (m_tvalid && m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Address split: drop the offset in ST_SHIFT, then the set index in ST_SPLIT.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            addr_reg <= s_tdata;
        if (state_reg == ST_SHIFT)
            shift_reg <= addr_reg >> block_bits_eff;
        if (state_reg == ST_SPLIT)
        begin
            set_reg <= shift_reg[SET_W-1:0] & ~({SET_W{1'b1}} << set_bits_eff);
            tag_reg <= TAG_W'(shift_reg >> set_bits_eff);
        end
    end

    // Result register; counts reflect this item's update.
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_UPDATE) && update_go)
        begin
            out_data_reg <= {6'd0,
                (!scan_stat.hit && !scan_stat.empty_seen
                    && (evictions_reg != {COUNT_W{1'b1}}))
                    ? evictions_reg + COUNT_W'(1) : evictions_reg,
                (!scan_stat.hit && (misses_reg != {COUNT_W{1'b1}}))
                    ? misses_reg + COUNT_W'(1) : misses_reg,
                (scan_stat.hit && (hits_reg != {COUNT_W{1'b1}}))
                    ? hits_reg + COUNT_W'(1) : hits_reg,
                outcome};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Line store: tag and last-use stamp, addressed by set and way.
    assign line_wr_en = (state_reg == ST_UPDATE) && update_go;

    salru_ram #(
        .WIDTH  (LINE_W),
        .ADDR_W (SET_W + WAY_IDX_W)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (line_wr_en),
        .wr_addr ({set_reg, victim}),
        .wr_data ({tag_reg, tick_inc}),
        .rd_addr ({set_reg, way_next}),
        .rd_data (line_rd_data)
    );

    // Valid store: one row of way bits per set, swept to zero after reset.
    always_comb
    begin
        if (state_reg == ST_CLEAR)
        begin
            valid_wr_en   = 1'b1;
            valid_wr_addr = clr_reg;
            valid_wr_data = '0;
        end
        else
        begin
            valid_wr_en   = line_wr_en;
            valid_wr_addr = set_reg;
            valid_wr_data = valid_rd_data | victim_mask;
        end
    end

    salru_ram #(
        .WIDTH  (MAX_WAYS),
        .ADDR_W (SET_W)
    ) u_valid_ram (
        .clk     (clk),
        .wr_en   (valid_wr_en),
        .wr_addr (valid_wr_addr),
        .wr_data (valid_wr_data),
        .rd_addr (set_reg),
        .rd_data (valid_rd_data)
    );

    salru_way_unit #(
        .WAY_IDX_W (WAY_IDX_W)
    ) u_way_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (scan_ctl),
        .way        (way_reg),
        .line_valid (valid_rd_data[way_reg]),
        .line_tag   (line_rd_data[LINE_W-1:STAMP_W]),
        .line_stamp (line_rd_data[STAMP_W-1:0]),
        .key_tag    (tag_reg),
        .stat       (scan_stat),
        .empty_way  (empty_way),
        .lru_way    (lru_way)
    );

endmodule

`default_nettype wire

### bench/set_assoc_lru_cache_sim_tb.sv
// Self-checking bench for set_assoc_lru_cache_sim: a mirror of the cache tracks
// LRU state and counts, and every output item is compared against it.
// Depends on salru_pkg and the set_assoc_lru_cache_sim RTL.
`timescale 1ns / 1ps

module set_assoc_lru_cache_sim_tb;

    import salru_pkg::*;

    localparam int SET_BITS_MAX  = 8;
    localparam int WAYS_MAX      = 8;
    localparam int LINE_COUNT    = (1 << SET_BITS_MAX) * WAYS_MAX;
    localparam int PHASE_ITEMS   = 150;
    localparam int SETTLE_CYCLES = 24;
    localparam int HOLD_CYCLES   = 400;
    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        outcome_t            outcome;
        logic [COUNT_W-1:0]  hits;
        logic [COUNT_W-1:0]  misses;
        logic [COUNT_W-1:0]  evictions;
    } access_result_t;

    class lru_cache_mirror;
        bit                  line_valid [LINE_COUNT];
        logic [ADDR_W-1:0]   line_tag   [LINE_COUNT];
        logic [STAMP_W-1:0]  line_stamp [LINE_COUNT];
        logic [3:0]          set_bits_q;
        logic [3:0]          ways_q;
        logic [5:0]          block_bits_q;
        logic [STAMP_W-1:0]  tick;
        logic [COUNT_W-1:0]  hits;
        logic [COUNT_W-1:0]  misses;
        logic [COUNT_W-1:0]  evictions;
        access_result_t      results_due [$];
        int                  errors;

        function new();
            foreach (line_valid[i])
            begin
                line_valid[i] = 1'b0;
                line_tag[i]   = '0;
                line_stamp[i] = '0;
            end
            set_bits_q   = SET_BITS_RESET;
            ways_q       = WAYS_USED_RESET;
            block_bits_q = BLOCK_BITS_RESET;
            tick         = '0;
            hits         = '0;
            misses       = '0;
            evictions    = '0;
            errors       = 0;
        endfunction

        function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                REG_SET_BITS:   set_bits_q = val[3:0];
                REG_WAYS_USED:  ways_q = val[3:0];
                REG_BLOCK_BITS: block_bits_q = val;
                default: ;
            endcase
        endfunction

        function int unsigned eff_set_bits();
            if (set_bits_q < 1)
                return 1;
            return (set_bits_q > SET_BITS_MAX) ? SET_BITS_MAX : set_bits_q;
        endfunction

        function int unsigned eff_ways();
            if (ways_q < 1)
                return 1;
            return (ways_q > WAYS_MAX) ? WAYS_MAX : ways_q;
        endfunction

        function int unsigned eff_block_bits();
            return (block_bits_q < 1) ? 1 : block_bits_q;
        endfunction

        function logic [COUNT_W-1:0] bump(logic [COUNT_W-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        // Looks up one access, updates the mirror and queues the expected item.
        function void note_address(logic [ADDR_W-1:0] addr);
            int unsigned         s, e, b, w, base, k, filled, victim;
            int                  empty_way, lru_way, hit_way;
            logic [ADDR_W-1:0]   set_idx, tag;
            logic [STAMP_W-1:0]  min_stamp;
            access_result_t      r;
            s = eff_set_bits();
            e = eff_ways();
            b = eff_block_bits();
            set_idx = (b >= ADDR_W) ? '0 : ((addr >> b) & ((64'd1 << s) - 64'd1));
            tag = (s + b >= ADDR_W) ? '0 : (addr >> (s + b));
            base = int'(set_idx[SET_BITS_MAX-1:0]) * WAYS_MAX;
            empty_way = -1;
            lru_way = -1;
            hit_way = -1;
            min_stamp = '0;
            filled = 0;
            for (w = 0; w < e; w++)
            begin
                k = base + w;
                if (!line_valid[k])
                begin
                    if (empty_way < 0)
                        empty_way = w;
                    continue;
                end
                filled++;
                // Ties keep the lower way, since only a strictly older stamp wins.
                if (lru_way < 0 || line_stamp[k] < min_stamp)
                begin
                    min_stamp = line_stamp[k];
                    lru_way = w;
                end
                if (line_tag[k] == tag)
                begin
                    hit_way = w;
                    break;
                end
            end
            tick = tick + 1'b1;
            if (hit_way >= 0)
            begin
                line_stamp[base + hit_way] = tick;
                hits = bump(hits);
                r.outcome = OUTCOME_HIT;
            end
            else
            begin
                misses = bump(misses);
                if (filled == e)
                begin
                    victim = (lru_way < 0) ? 0 : lru_way;
                    evictions = bump(evictions);
                    r.outcome = OUTCOME_EVICT;
                end
                else
                begin
                    victim = (empty_way < 0) ? 0 : empty_way;
                    r.outcome = OUTCOME_FILL;
                end
                line_valid[base + victim] = 1'b1;
                line_tag[base + victim]   = tag;
                line_stamp[base + victim] = tick;
            end
            r.hits = hits;
            r.misses = misses;
            r.evictions = evictions;
            results_due.push_back(r);
        endfunction

        function void compare(string field, logic [COUNT_W-1:0] want, logic [COUNT_W-1:0] got);
            if (want !== got)
            begin
                $display("%0t: %s expected %0d actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] d);
            access_result_t want;
            if (results_due.size() == 0)
            begin
                $display("%0t: unexpected item, expected none actual %h", $time, d);
                errors++;
                return;
            end
            want = results_due.pop_front();
            compare("outcome", want.outcome, d[1:0]);
            compare("hit_count", want.hits, d[33:2]);
            compare("miss_count", want.misses, d[65:34]);
            compare("eviction_count", want.evictions, d[97:66]);
        endfunction

        function int outstanding();
            return results_due.size();
        endfunction
    endclass

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     s_tvalid = 1'b0;
    logic                     s_tready;
    logic [ADDR_W-1:0]        s_tdata = '0;
    logic                     m_tvalid;
    logic                     m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]   m_tdata;
    logic                     cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0]    cfg_addr = '0;
    logic [CFG_DATA_W-1:0]    cfg_wdata = '0;

    lru_cache_mirror          cache_mirror = new();
    int                       send_idle_pct = 38;
    int                       recv_idle_pct = 68;
    bit                       hold_request = 1'b0;
    int                       stall_left = 0;
    logic [ADDR_W-1:0]        tag_salt = '0;

    set_assoc_lru_cache_sim #(
        .MAX_SET_BITS (SET_BITS_MAX),
        .MAX_WAYS     (WAYS_MAX)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #10 clk = ~clk;

    // Output side: checks each taken item, then picks the next ready value.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                cache_mirror.check_result(m_tdata);
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic push_address(input logic [ADDR_W-1:0] addr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= addr;
        do
            @(posedge clk);
        while (!s_tready);
        cache_mirror.note_address(addr);
    endtask

    // Drains all outstanding items and lets the write-back finish.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (cache_mirror.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cache_mirror.write_reg(idx, val);
    endtask

    task automatic configure(input logic [3:0] sb, input logic [3:0] wu, input logic [5:0] bb);
        write_reg(REG_SET_BITS, {2'b00, sb});
        write_reg(REG_WAYS_USED, {2'b00, wu});
        write_reg(REG_BLOCK_BITS, bb);
        cfg_we <= 1'b0;
    endtask

    // Mostly a small working set of tags over a few sets, so that hits,
    // fills and LRU evictions all occur; the rest are arbitrary addresses.
    function automatic logic [ADDR_W-1:0] pick_address();
        int unsigned         s, b, e, nsets, span;
        logic [ADDR_W-1:0]   tag, set_idx, offset;
        s = cache_mirror.eff_set_bits();
        b = cache_mirror.eff_block_bits();
        e = cache_mirror.eff_ways();
        offset = {$urandom, $urandom};
        if ($urandom_range(99) < 12)
            return offset;
        nsets = 1 << s;
        span = (nsets > 4) ? 3 : nsets - 1;
        set_idx = ($urandom_range(3) == 0) ? $urandom_range(nsets - 1) : $urandom_range(span);
        tag = tag_salt + $urandom_range(e + 2);
        return (tag << (s + b)) | (set_idx << b) | (offset & ((64'd1 << b) - 64'd1));
    endfunction

    task automatic run_phase(input logic [3:0] sb, input logic [3:0] wu, input logic [5:0] bb,
                             input int send_pct, input int recv_pct, input bit with_hold);
        int i;
        settle();
        configure(sb, wu, bb);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        tag_salt = $urandom_range(1) ? {$urandom, $urandom} : '0;
        for (i = 0; i < PHASE_ITEMS; i++)
        begin
            if (with_hold && i == 20)
                hold_request = 1'b1;
            push_address(pick_address());
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        settle();

        // Reset geometry: one way, so a second tag in a set evicts at once.
        push_address(64'h0);
        push_address(64'h0F);
        push_address(64'hFFFF_FFFF_FFFF_FFFF);
        push_address(64'h100);
        push_address(64'h0);
        push_address(64'hFFFF_FFFF_FFFF_FFF0);

        // Zero in every register acts as one; old lines still match by tag.
        settle();
        write_reg(REG_UNUSED, 6'h2A);
        configure(4'd0, 4'd0, 6'd0);
        push_address(64'h0);
        push_address(64'h2);
        push_address(64'h4);

        // Values above the built limits clamp; the top bit is the whole index.
        settle();
        configure(4'd15, 4'd15, 6'd63);
        push_address(64'h0);
        push_address(64'h8000_0000_0000_0000);
        push_address(64'hFFFF_FFFF_FFFF_FFFF);
        push_address(64'h7FFF_FFFF_FFFF_FFFF);

        // Offset plus index spans the whole address, so every tag is zero.
        settle();
        configure(4'd8, 4'd2, 6'd56);
        push_address(64'hFF00_0000_0000_0000);
        push_address(64'hFF12_3456_789A_BCDE);
        push_address(64'h0100_0000_0000_0000);

        run_phase(4'd1, 4'd2, 6'd1, 38, 68, 1'b0);
        run_phase(4'd8, 4'd8, 6'd6, 38, 68, 1'b0);
        run_phase(4'd3, 4'd4, 6'd12, 38, 68, 1'b0);
        run_phase(4'd15, 4'd15, 6'd63, 68, 38, 1'b0);
        run_phase(4'd2, 4'd3, 6'd55, 68, 38, 1'b0);
        run_phase(4'd5, 4'd6, 6'd33, 68, 38, 1'b0);
        run_phase(4'd8, 4'd8, 6'd56, 0, 0, 1'b1);
        run_phase(4'd1, 4'd8, 6'd1, 0, 0, 1'b0);
        run_phase(4'd4, 4'd1, 6'd4, 0, 0, 1'b0);
        settle();

        if (cache_mirror.errors == 0 && cache_mirror.outstanding() == 0)
            $display("set_assoc_lru_cache_sim_tb OK");
        else
            $display("set_assoc_lru_cache_sim_tb NOT OK");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("set_assoc_lru_cache_sim_tb NOT OK");
        $finish;
    end

endmodule

### set_assoc_lru_cache_sim.f
src/salru_pkg.sv
src/salru_ram.sv
src/salru_way_unit.sv
src/set_assoc_lru_cache_sim.sv
bench/set_assoc_lru_cache_sim_tb.sv
